FILE: src/tpe_pkg.sv
// shared types and constants for the tape pair edit distance unit
`timescale 1ns / 1ps
`default_nettype none
package tpe_pkg;

    localparam int TOKEN_W     = 16;
    localparam int DEPTH_W     = 4;
    localparam int PREFIX_W    = 4;
    localparam int DIST_W      = 5;
    localparam int SUM_W       = 11;
    localparam int COUNT_W     = 7;
    localparam int MEAN_W      = 13;
    localparam int FRAC_BITS   = 8;
    localparam int NUM_W       = SUM_W + FRAC_BITS + 1;
    localparam int STEP_W      = $clog2(NUM_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PREFIX_W-1:0] PREFIX_MAX = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [NUM_W-1:0]    MEAN_MAX   = NUM_W'((1 << MEAN_W) - 1);

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } t_pair;

endpackage
`default_nettype wire

FILE: src/tpe_front.sv
// front end: shared prefix tracking, per-tape distance, sum and shared count
`timescale 1ns / 1ps
`default_nettype none
module tpe_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [tpe_pkg::TOKEN_W-1:0]  i_token_a,
    input  wire logic [tpe_pkg::TOKEN_W-1:0]  i_token_b,
    input  wire logic                         i_recovered_a,
    input  wire logic                         i_recovered_b,
    input  wire logic [tpe_pkg::DEPTH_W-1:0]  i_depth_a,
    input  wire logic [tpe_pkg::DEPTH_W-1:0]  i_depth_b,
    input  wire logic                         i_last_site,
    input  wire logic                         i_last_tape,
    output tpe_pkg::t_pair                    o_push_data,
    output logic                              o_push
);
    import tpe_pkg::*;

    logic [PREFIX_W-1:0] r_plen, n_plen;
    logic                r_run, n_run;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [COUNT_W-1:0]  r_cnt, n_cnt;
    logic [DIST_W-1:0]   total, twice, tape_dist;
    logic [SUM_W:0]      sum_add;
    logic                shared;

    always_comb begin
        n_plen = r_plen;
        n_run  = r_run;
        if (r_run) begin
            if (i_token_a != '0 && i_token_a == i_token_b) begin
                if (r_plen != PREFIX_MAX) begin
                    n_plen = r_plen + 1'b1;
                end
            end else begin
                n_run = 1'b0;
            end
        end
    end

    assign total     = DIST_W'(i_depth_a) + DIST_W'(i_depth_b);
    assign twice     = {n_plen, 1'b0};
    assign tape_dist = (total > twice) ? (total - twice) : '0;
    assign sum_add   = {1'b0, r_sum} + (SUM_W + 1)'(tape_dist);
    assign shared    = i_recovered_a && i_recovered_b;

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (i_last_site && shared) begin
            n_sum = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            n_cnt = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
        end
    end

    assign o_push            = i_accept && i_last_site && i_last_tape;
    assign o_push_data.count = n_cnt;
    assign o_push_data.sum   = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_run  <= 1'b1;
            r_sum  <= '0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            if (i_last_site) begin
                r_plen <= '0;
                r_run  <= 1'b1;
            end else begin
                r_plen <= n_plen;
                r_run  <= n_run;
            end
            if (i_last_site && i_last_tape) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/tpe_queue.sv
// short queue of finished pair totals between front and back
`timescale 1ns / 1ps
`default_nettype none
module tpe_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire tpe_pkg::t_pair i_push_data,
    output logic        o_not_full,
    input  wire logic   i_pop,
    output logic        o_not_empty,
    output tpe_pkg::t_pair o_pop_data
);
    import tpe_pkg::*;

    t_pair              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_fill;
    logic               do_push, do_pop;

    assign o_not_full  = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_fill != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_pop_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/tpe_back.sv
// back end: bit-serial mean divider and output register
`timescale 1ns / 1ps
`default_nettype none
module tpe_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_pair_valid,
    input  wire tpe_pkg::t_pair              i_pair,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_has_shared,
    output logic [tpe_pkg::COUNT_W-1:0]      o_shared_tapes,
    output logic [tpe_pkg::SUM_W-1:0]        o_distance_sum,
    output logic [tpe_pkg::MEAN_W-1:0]       o_mean_distance
);
    import tpe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state;
    logic [STEP_W-1:0]  r_step;
    logic [NUM_W-1:0]   r_quo;
    logic [COUNT_W-1:0] r_rem, r_div;
    logic [SUM_W-1:0]   r_sum;
    logic               r_ovalid, r_ohas;
    logic [COUNT_W-1:0] r_ocnt;
    logic [SUM_W-1:0]   r_osum;
    logic [MEAN_W-1:0]  r_omean;

    logic [COUNT_W:0]   rem_sh, rem_diff;
    logic               ge;
    logic [NUM_W-1:0]   num;
    logic               out_free;

    assign rem_sh   = {r_rem, r_quo[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign ge       = (rem_sh >= {1'b0, r_div});
    assign num      = {1'b0, i_pair.sum, {FRAC_BITS{1'b0}}}
                    + NUM_W'(i_pair.count >> 1);
    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_pair_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_pair_valid) begin
                        r_step  <= '0;
                        r_state <= (i_pair.count == '0) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_div <= i_pair.count;
            r_sum <= i_pair.sum;
            r_rem <= '0;
            r_quo <= (i_pair.count == '0) ? '0 : num;
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
        if (r_state == S_DONE && out_free) begin
            r_ohas  <= (r_div != '0);
            r_ocnt  <= r_div;
            r_osum  <= r_sum;
            r_omean <= (r_quo > MEAN_MAX) ? MEAN_MAX[MEAN_W-1:0] : r_quo[MEAN_W-1:0];
        end
    end

    assign o_valid         = r_ovalid;
    assign o_has_shared    = r_ohas;
    assign o_shared_tapes  = r_ocnt;
    assign o_distance_sum  = r_osum;
    assign o_mean_distance = r_omean;

    a_na_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_ohas |-> (r_ocnt == '0) && (r_osum == '0) && (r_omean == '0))
        else $error("no-shared result carries nonzero fields");

    a_has_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ohas == (r_ocnt != '0)))
        else $error("has_shared disagrees with shared count");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> (r_div != '0) && (r_step < STEP_W'(NUM_W)))
        else $error("divider running with zero divisor or past its step count");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_step != STEP_W'(NUM_W - 1) |=> r_state == S_DIV)
        else $error("divider left early");

endmodule
`default_nettype wire

FILE: src/tape_pair_edit_distance_unit.sv
// top level of the tape pair edit distance unit
//
// Sites stream in one per cycle: the front end tracks the shared prefix of each
// tape and folds every tape that both cells recovered into a saturating sum and
// count. The item carrying last_site and last_tape closes the pair and pushes its
// count and sum into a two-entry queue. The back end takes one pair at a time and
// forms the mean with a restoring divider that retires one quotient bit per cycle;
// the front keeps taking sites meanwhile and stalls only when the queue is full.
// The result waits in an output register until taken; the divider may work on the
// next pair meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module tape_pair_edit_distance_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [tpe_pkg::TOKEN_W-1:0]  i_token_a,
    input  wire logic [tpe_pkg::TOKEN_W-1:0]  i_token_b,
    input  wire logic                         i_recovered_a,
    input  wire logic                         i_recovered_b,
    input  wire logic [tpe_pkg::DEPTH_W-1:0]  i_depth_a,
    input  wire logic [tpe_pkg::DEPTH_W-1:0]  i_depth_b,
    input  wire logic                         i_last_site,
    input  wire logic                         i_last_tape,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_has_shared,
    output logic [tpe_pkg::COUNT_W-1:0]       o_shared_tapes,
    output logic [tpe_pkg::SUM_W-1:0]         o_distance_sum,
    output logic [tpe_pkg::MEAN_W-1:0]        o_mean_distance
);
    import tpe_pkg::*;

    t_pair push_data, pop_data;
    logic  push, q_not_full, q_not_empty, pop;

    assign o_ready = q_not_full;

    tpe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (i_valid && q_not_full),
        .i_token_a     (i_token_a),
        .i_token_b     (i_token_b),
        .i_recovered_a (i_recovered_a),
        .i_recovered_b (i_recovered_b),
        .i_depth_a     (i_depth_a),
        .i_depth_b     (i_depth_b),
        .i_last_site   (i_last_site),
        .i_last_tape   (i_last_tape),
        .o_push_data   (push_data),
        .o_push        (push)
    );

    tpe_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_pop_data  (pop_data)
    );

    tpe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pair_valid    (q_not_empty),
        .i_pair          (pop_data),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_has_shared    (o_has_shared),
        .o_shared_tapes  (o_shared_tapes),
        .o_distance_sum  (o_distance_sum),
        .o_mean_distance (o_mean_distance)
    );

endmodule
`default_nettype wire
